// ----- sv/dqu_pkg.sv -----
// Shared constants, command codes and status type for the double-ended queue unit.
package dqu_pkg;

    localparam int DQU_DEPTH      = 16;
    localparam int DQU_DATA_WIDTH = 8;
    localparam int CMD_W          = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NOP        = 3'd4;

    typedef struct packed {
        logic not_empty;
        logic is_full;
        logic error;
    } dqu_status_t;

endpackage

// ----- sv/dqu_ram.sv -----
// Element store: one write port, two registered read ports, write-first on a same-entry hit.
module dqu_ram
    import dqu_pkg::*;
#(
    parameter int DEPTH      = DQU_DEPTH,
    parameter int DATA_WIDTH = DQU_DATA_WIDTH,
    localparam int ADDR_W    = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr_a,
    input  logic [ADDR_W-1:0]     rd_addr_b,
    output logic [DATA_WIDTH-1:0] rd_data_a,
    output logic [DATA_WIDTH-1:0] rd_data_b
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_a_reg;
    logic [DATA_WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // forward the word being written when a read hits the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
            rd_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- sv/dqu_ctrl.sv -----
// Pointer and count control: decodes a command, updates head, tail and count, drives the store.
module dqu_ctrl
    import dqu_pkg::*;
#(
    parameter int DEPTH      = DQU_DEPTH,
    parameter int DATA_WIDTH = DQU_DATA_WIDTH,
    localparam int ADDR_W    = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [CMD_W-1:0]      command,
    input  logic [DATA_WIDTH-1:0] data_in,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [DATA_WIDTH-1:0] wr_data,
    output logic [ADDR_W-1:0]     front_addr,
    output logic [ADDR_W-1:0]     rear_addr,
    output logic [CNT_W-1:0]      count_next,
    output dqu_status_t           status
);

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [ADDR_W-1:0] tail_reg;
    logic [ADDR_W-1:0] tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic              full;
    logic              empty;
    logic              push_ok;
    logic              err;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_W'(DEPTH - 1) : p - ADDR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        push_ok    = 1'b0;
        wr_addr    = tail_reg;
        err        = 1'b0;
        unique case (command)
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    err = 1'b1;
                end
                else
                begin
                    head_next  = ptr_dec(head_reg);
                    wr_addr    = head_next;
                    push_ok    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    err = 1'b1;
                end
                else
                begin
                    wr_addr    = tail_reg;
                    tail_next  = ptr_inc(tail_reg);
                    push_ok    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    err = 1'b1;
                end
                else
                begin
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    err = 1'b1;
                end
                else
                begin
                    tail_next  = ptr_dec(tail_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                err = 1'b0;
            end
        endcase
        // an emptied queue restarts at entry zero
        if (count_next == '0)
        begin
            head_next = '0;
            tail_next = '0;
        end
    end

    assign wr_en      = accept && push_ok;
    assign wr_data    = data_in;
    assign front_addr = head_next;
    assign rear_addr  = ptr_dec(tail_next);

    assign status.not_empty = (count_next != '0);
    assign status.is_full   = (count_next == CNT_W'(DEPTH));
    assign status.error     = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with pointers away from zero");

    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err) |=> $stable(count_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("rejected command changed the queue");

    a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        err |-> !wr_en)
        else $error("store written by a rejected command");

endmodule

// ----- sv/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: control, element store and result register.
//
// Input channel (in_valid / in_ready) carries one command word: command selects
// push front (0), push back (1), pop front (2), pop back (3) or no operation
// (4; codes 5 to 7 act the same). data_in is the element for a push.
// Output channel (out_valid / out_ready) returns one result word per command:
// front and rear elements (zero when empty), not_empty, entry_count, is_full and
// error. A pop on an empty queue or a push on a full one changes nothing and
// sets error.
// On acceptance the pointers update, the store is written and both reads
// launch with the status into the read stage; when the result register is free
// or draining, the read stage loads it and raises out_valid. Throughput is one
// command per cycle while out_ready stays high, set by the single write port
// and the two registered read ports of the store.
// When the receiver stalls, the result register holds and one more command
// may complete its read; after that in_ready drops until out_ready returns.
// Reset empties the queue (pointers and count to zero) and clears both valid
// flags; store contents are left as they are and are never reported until written.
module double_ended_queue_unit
    import dqu_pkg::*;
#(
    parameter int DEPTH      = DQU_DEPTH,
    parameter int DATA_WIDTH = DQU_DATA_WIDTH,
    localparam int ADDR_W    = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [DATA_WIDTH-1:0] data_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] front_value,
    output logic [DATA_WIDTH-1:0] rear_value,
    output logic                  not_empty,
    output logic [CNT_W-1:0]      entry_count,
    output logic                  is_full,
    output logic                  error
);

    logic                  accept;
    logic                  s1_move;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [ADDR_W-1:0]     front_addr;
    logic [ADDR_W-1:0]     rear_addr;
    logic [CNT_W-1:0]      count_next;
    dqu_status_t           status;
    logic [DATA_WIDTH-1:0] rd_front;
    logic [DATA_WIDTH-1:0] rd_rear;

    // read stage: status travels alongside the store read
    logic                  s1_valid_reg;
    dqu_status_t           s1_status_reg;
    logic [CNT_W-1:0]      s1_count_reg;

    // result register
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] rear_reg;
    dqu_status_t           out_status_reg;
    logic [CNT_W-1:0]      out_count_reg;

    // advance the read stage whenever the result register is free or draining
    assign s1_move  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    dqu_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .data_in    (data_in),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .front_addr (front_addr),
        .rear_addr  (rear_addr),
        .count_next (count_next),
        .status     (status)
    );

    // reads launch only on accept, so the read data holds while stage one stalls
    dqu_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (accept),
        .rd_addr_a  (front_addr),
        .rd_addr_b  (rear_addr),
        .rd_data_a  (rd_front),
        .rd_data_b  (rd_rear)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_count_reg  <= count_next;
        end
        if (s1_valid_reg && s1_move)
        begin
            // report zero for both ends of an empty queue
            front_reg      <= s1_status_reg.not_empty ? rd_front : '0;
            rear_reg       <= s1_status_reg.not_empty ? rd_rear : '0;
            out_status_reg <= s1_status_reg;
            out_count_reg  <= s1_count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_value = front_reg;
    assign rear_value  = rear_reg;
    assign not_empty   = out_status_reg.not_empty;
    assign entry_count = out_count_reg;
    assign is_full     = out_status_reg.is_full;
    assign error       = out_status_reg.error;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are stalled");

    a_empty_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_status_reg.not_empty) |->
            (front_reg == '0) && (rear_reg == '0))
        else $error("nonzero element reported for an empty queue");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg.is_full == (out_count_reg == CNT_W'(DEPTH))))
        else $error("full flag disagrees with count");

    a_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_move) |=> out_valid_reg)
        else $error("read stage dropped a result");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue_unit: directed table, biased random, checker.
module tb;
    import dqu_pkg::*;

    localparam int CNT_W      = $clog2(DQU_DEPTH + 1);
    localparam int PTR_W      = $clog2(DQU_DEPTH);
    localparam int DIR_ROWS   = 25;
    localparam int RAND_WORDS = 850;
    localparam int PHASES     = 4;
    localparam int CHUNK      = 32;

    typedef logic [DQU_DATA_WIDTH-1:0] elem_t;
    typedef logic [PTR_W-1:0]          ptr_t;

    // One result word as the block reports it.
    typedef struct packed {
        elem_t             front;
        elem_t             rear;
        logic [CNT_W-1:0]  count;
        dqu_status_t       flags;
    } deque_view_t;

    // One directed command; want is used only where typed is set.
    typedef struct {
        logic [CMD_W-1:0] op;
        elem_t            value;
        bit               typed;
        deque_view_t      want;
    } dir_row_t;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [CMD_W-1:0]  command     = CMD_NOP;
    elem_t             data_in     = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    elem_t             front_value;
    elem_t             rear_value;
    logic              not_empty;
    logic [CNT_W-1:0]  entry_count;
    logic              is_full;
    logic              error;

    // Shadow copy of the queue, advanced once per accepted command word.
    elem_t             ring [DQU_DEPTH];
    ptr_t              front_ptr   = '0;
    ptr_t              back_ptr    = '0;
    int unsigned       held_count  = 0;

    deque_view_t       pending_views[$];
    dir_row_t          dir_table [DIR_ROWS];
    int unsigned       accepted_words = 0;
    int unsigned       result_words   = 0;
    int unsigned       fault_count    = 0;
    int unsigned       sender_idle_pct = 0;
    int unsigned       stall_pct       = 0;

    double_ended_queue_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .front_value (front_value),
        .rear_value  (rear_value),
        .not_empty   (not_empty),
        .entry_count (entry_count),
        .is_full     (is_full),
        .error       (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop as a watchdog, far beyond what a full run needs.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Apply one command to the shadow queue and return the word the block should report.
    // The front pointer sits on the front entry, the back pointer on the free slot past
    // the rear entry. Pointers wrap naturally since the depth is a power of two.
    function automatic deque_view_t apply_command(input logic [CMD_W-1:0] op,
                                                  input elem_t value);
        deque_view_t view;
        ptr_t        last;
        logic        fault;
        fault = 1'b0;
        case (op)
            CMD_PUSH_FRONT:
            begin
                if (held_count == DQU_DEPTH)
                    fault = 1'b1;
                else
                begin
                    front_ptr       = front_ptr - ptr_t'(1);
                    ring[front_ptr] = value;
                    held_count++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (held_count == DQU_DEPTH)
                    fault = 1'b1;
                else
                begin
                    ring[back_ptr] = value;
                    back_ptr       = back_ptr + ptr_t'(1);
                    held_count++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (held_count == 0)
                    fault = 1'b1;
                else
                begin
                    front_ptr = front_ptr + ptr_t'(1);
                    held_count--;
                end
            end
            CMD_POP_BACK:
            begin
                if (held_count == 0)
                    fault = 1'b1;
                else
                begin
                    back_ptr = back_ptr - ptr_t'(1);
                    held_count--;
                end
            end
            default: ;  // no operation, including the unused codes
        endcase
        // A pop that empties the queue puts both pointers back to zero.
        if (held_count == 0)
        begin
            front_ptr = '0;
            back_ptr  = '0;
        end
        last            = back_ptr - ptr_t'(1);
        view.front      = (held_count != 0) ? ring[front_ptr] : '0;
        view.rear       = (held_count != 0) ? ring[last] : '0;
        view.count      = CNT_W'(held_count);
        view.flags      = '{not_empty: (held_count != 0),
                            is_full:   (held_count == DQU_DEPTH),
                            error:     fault};
        return view;
    endfunction

    // Receiver: stall at the rate of the current phase.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Monitor both channels in one process so prediction and checking never race.
    always @(posedge clk)
    begin
        deque_view_t pred;
        deque_view_t got;
        if (rst_n)
        begin
            // Predict every accepted command word; directed rows may carry a typed result.
            if (in_valid && in_ready)
            begin
                pred = apply_command(command, data_in);
                if (accepted_words < DIR_ROWS && dir_table[accepted_words].typed)
                    pred = dir_table[accepted_words].want;
                pending_views.insert(pending_views.size(), pred);
                accepted_words++;
            end
            // Check every accepted result word against the oldest prediction.
            if (out_valid && out_ready)
            begin
                got = '{front_value, rear_value, entry_count, '{not_empty, is_full, error}};
                if (pending_views.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("result word %0d arrived with nothing pending", result_words);
                    fault_count++;
                end
                else
                begin
                    pred = pending_views[0];
                    pending_views.delete(0);
                    if (got.front !== pred.front || got.rear !== pred.rear
                        || got.count !== pred.count
                        || got.flags.not_empty !== pred.flags.not_empty
                        || got.flags.is_full !== pred.flags.is_full
                        || got.flags.error !== pred.flags.error)
                    begin
                        if (fault_count < 10)
                        begin
                            $display("result word %0d: expected front %h rear %h count %0d ne %b full %b err %b",
                                     result_words, pred.front, pred.rear, pred.count,
                                     pred.flags.not_empty, pred.flags.is_full,
                                     pred.flags.error);
                            $display("result word %0d: got      front %h rear %h count %0d ne %b full %b err %b",
                                     result_words, got.front, got.rear, got.count,
                                     got.flags.not_empty, got.flags.is_full,
                                     got.flags.error);
                        end
                        fault_count++;
                    end
                end
                result_words++;
            end
        end
    end

    // Offer one command word after a random idle stretch; hold it until accepted.
    task automatic send_word(input logic [CMD_W-1:0] op, input elem_t value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= op;
        data_in  <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold off until every predicted word has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_views.size() != 0);
    endtask

    // Stimulus: directed table first, then four phases of biased random traffic with differing idle and stall rates.
    initial
    begin
        logic [CMD_W-1:0] op;
        int unsigned      push_bias;
        int unsigned      pick;
        int unsigned      sender_by_phase [PHASES];
        int unsigned      stall_by_phase [PHASES];

        sender_by_phase = '{0, 76, 0, 12};
        stall_by_phase  = '{0, 0, 76, 12};

        // Empty queue: no-op, pops on empty, unused code; then push both ends,
        // pop both ends back down to empty.
        dir_table[0] = '{CMD_NOP,        8'h00, 1'b1,
                         '{8'h00, 8'h00, CNT_W'(0), '{1'b0, 1'b0, 1'b0}}};
        dir_table[1] = '{CMD_POP_FRONT,  8'hA5, 1'b1,
                         '{8'h00, 8'h00, CNT_W'(0), '{1'b0, 1'b0, 1'b1}}};
        dir_table[2] = '{CMD_POP_BACK,   8'h5A, 1'b1,
                         '{8'h00, 8'h00, CNT_W'(0), '{1'b0, 1'b0, 1'b1}}};
        dir_table[3] = '{CMD_NOP + 3'd1, 8'hFF, 1'b1,
                         '{8'h00, 8'h00, CNT_W'(0), '{1'b0, 1'b0, 1'b0}}};
        dir_table[4] = '{CMD_PUSH_BACK,  8'hFF, 1'b1,
                         '{8'hFF, 8'hFF, CNT_W'(1), '{1'b1, 1'b0, 1'b0}}};
        dir_table[5] = '{CMD_PUSH_FRONT, 8'h00, 1'b1,
                         '{8'h00, 8'hFF, CNT_W'(2), '{1'b1, 1'b0, 1'b0}}};
        dir_table[6] = '{CMD_POP_BACK,   8'h33, 1'b1,
                         '{8'h00, 8'h00, CNT_W'(1), '{1'b1, 1'b0, 1'b0}}};
        dir_table[7] = '{CMD_POP_FRONT,  8'hCC, 1'b1,
                         '{8'h00, 8'h00, CNT_W'(0), '{1'b0, 1'b0, 1'b0}}};
        // Fill to capacity from alternating ends with walking-one / walking-zero data,
        // wrapping the front pointer below zero on the way.
        for (int i = 0; i < DQU_DEPTH; i++)
        begin
            dir_table[8 + i].op    = (i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            dir_table[8 + i].value = (i % 2) ? ~(elem_t'(1) << (i / 2)) : elem_t'(1) << (i / 2);
            dir_table[8 + i].typed = 1'b0;
            dir_table[8 + i].want  = '0;
        end
        // Push on a full queue: data dropped, error raised.
        dir_table[24] = '{CMD_PUSH_BACK, 8'h77, 1'b0, '0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_word(dir_table[r].op, dir_table[r].value);
        drain_results();

        // Random part: chunks lean toward pushes, pops or neither so the queue
        // swings between full and empty and hits both error cases often.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            sender_idle_pct = sender_by_phase[ph];
            stall_pct       = stall_by_phase[ph];
            push_bias       = 50;
            for (int n = 0; n < RAND_WORDS / PHASES; n++)
            begin
                if (n % CHUNK == 0)
                begin
                    pick      = $urandom_range(2);
                    push_bias = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
                end
                if ($urandom_range(99) < 6)
                    op = CMD_NOP + CMD_W'($urandom_range(3));
                else if ($urandom_range(99) < push_bias)
                    op = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    op = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                send_word(op, elem_t'($urandom_range(255)));
            end
            // Pause the sender until the block is fully drained between phases.
            drain_results();
        end

        // Leave room for any stray result word to show up.
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dqu_pkg.sv
sv/dqu_ram.sv
sv/dqu_ctrl.sv
sv/double_ended_queue_unit.sv
dv/tb.sv
